### hdl/rprop_pkg.sv
// Shared types and constants for the Rprop element update pipeline.
`default_nettype none

package rprop_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Step factors are unsigned Q4.12
    localparam int ETA_W    = 16;
    localparam int ETA_FRAC = 12;
    localparam int STEP_CFG_W = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ETA_MINUS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_PLUS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAXIMIZE_MODE = 3'd4;

    // Reset values of the configuration registers
    localparam logic [ETA_W-1:0]      ETA_MINUS_RST = 16'd2048;
    localparam logic [ETA_W-1:0]      ETA_PLUS_RST  = 16'd4915;
    localparam logic [STEP_CFG_W-1:0] STEP_MIN_RST  = 32'd1;
    localparam logic [STEP_CFG_W-1:0] STEP_MAX_RST  = 32'd3276800;

    // Per-item control that travels down the pipeline with the data
    typedef struct packed {
        logic last;   // final element of a tensor
        logic gneg;   // effective gradient is negative
        logic move;   // parameter moves (gradient nonzero, no reversal)
        logic scale;  // step gets scaled by the selected factor
    } rprop_flags_t;

endpackage

`default_nettype wire

### hdl/rprop_cfg.sv
// Configuration registers and derived step clamp bounds.
`default_nettype none

module rprop_cfg #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    input  wire logic [rprop_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rprop_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic      [rprop_pkg::ETA_W-1:0]          eta_minus,
    output logic      [rprop_pkg::ETA_W-1:0]          eta_plus,
    output logic      [DATA_WIDTH-1:0]                step_lo,
    output logic      [DATA_WIDTH-1:0]                step_hi,
    output logic                                      maximize
);
    import rprop_pkg::*;

    logic [ETA_W-1:0]      eta_minus_reg;
    logic [ETA_W-1:0]      eta_plus_reg;
    logic [STEP_CFG_W-1:0] step_min_reg;
    logic [STEP_CFG_W-1:0] step_max_reg;
    logic                  maximize_reg;

    // Capture register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_minus_reg <= ETA_MINUS_RST;
            eta_plus_reg  <= ETA_PLUS_RST;
            step_min_reg  <= STEP_MIN_RST;
            step_max_reg  <= STEP_MAX_RST;
            maximize_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ETA_MINUS:     eta_minus_reg <= cfg_data[ETA_W-1:0];
                REG_ETA_PLUS:      eta_plus_reg  <= cfg_data[ETA_W-1:0];
                REG_STEP_MIN:      step_min_reg  <= cfg_data[STEP_CFG_W-1:0];
                REG_STEP_MAX:      step_max_reg  <= cfg_data[STEP_CFG_W-1:0];
                REG_MAXIMIZE_MODE: maximize_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign eta_minus = eta_minus_reg;
    assign eta_plus  = eta_plus_reg;
    assign maximize  = maximize_reg;

    // Fit the clamp bounds to the data width, saturating when they do not fit
    generate
        if (DATA_WIDTH >= STEP_CFG_W)
        begin : g_wide
            assign step_lo = DATA_WIDTH'(step_min_reg);
            assign step_hi = DATA_WIDTH'(step_max_reg);
        end
        else
        begin : g_narrow
            assign step_lo = (|step_min_reg[STEP_CFG_W-1:DATA_WIDTH]) ?
                             {DATA_WIDTH{1'b1}} : step_min_reg[DATA_WIDTH-1:0];
            assign step_hi = (|step_max_reg[STEP_CFG_W-1:DATA_WIDTH]) ?
                             {DATA_WIDTH{1'b1}} : step_max_reg[DATA_WIDTH-1:0];
        end
    endgenerate

endmodule

`default_nettype wire

### hdl/rprop_sign.sv
// First pipeline stage: gradient polarity, sign comparison and factor select.
`default_nettype none

module rprop_sign #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [rprop_pkg::ETA_W-1:0]       eta_minus,
    input  wire logic [rprop_pkg::ETA_W-1:0]       eta_plus,
    input  wire logic                              maximize,
    input  wire logic                              up_valid,
    output logic                                   up_stall,
    input  wire logic [DATA_WIDTH-1:0]             param,
    input  wire logic [DATA_WIDTH-1:0]             grad,
    input  wire logic [DATA_WIDTH-1:0]             prev_grad,
    input  wire logic [DATA_WIDTH-1:0]             step,
    input  wire logic                              last,
    output logic                                   dn_valid,
    input  wire logic                              dn_stall,
    output logic      [DATA_WIDTH-1:0]             dn_param,
    output logic      [DATA_WIDTH-1:0]             dn_grad,
    output logic      [DATA_WIDTH-1:0]             dn_step,
    output logic      [rprop_pkg::ETA_W-1:0]       dn_eta,
    output rprop_pkg::rprop_flags_t                dn_flags
);
    import rprop_pkg::*;

    localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] param_reg;
    logic [DATA_WIDTH-1:0] grad_reg;
    logic [DATA_WIDTH-1:0] step_reg;
    logic [ETA_W-1:0]      eta_reg;
    rprop_flags_t          flags_reg;

    logic [DATA_WIDTH-1:0] grad_next;
    logic [ETA_W-1:0]      eta_next;
    rprop_flags_t          flags_next;
    logic [DATA_WIDTH-1:0] geff;
    logic                  reversal;
    logic                  advance;

    // Negate in maximize mode, saturating the most negative value
    always_comb
    begin
        if (!maximize)
            geff = grad;
        else if (grad == MOST_NEG)
            geff = MOST_POS;
        else
            geff = -grad;
    end

    // Compare signs and pick the step factor
    always_comb
    begin
        flags_next.last  = last;
        flags_next.gneg  = geff[DATA_WIDTH-1];
        flags_next.scale = (|geff) && (|prev_grad);
        reversal         = flags_next.scale && (geff[DATA_WIDTH-1] != prev_grad[DATA_WIDTH-1]);
        flags_next.move  = (|geff) && !reversal;
        eta_next         = reversal ? eta_minus : eta_plus;
        grad_next        = reversal ? '0 : geff;
    end

    assign advance  = !valid_reg || !dn_stall;
    assign up_stall = !advance;

    // Hold on stall, otherwise load the next item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            param_reg <= param;
            grad_reg  <= grad_next;
            step_reg  <= step;
            eta_reg   <= eta_next;
            flags_reg <= flags_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_param = param_reg;
    assign dn_grad  = grad_reg;
    assign dn_step  = step_reg;
    assign dn_eta   = eta_reg;
    assign dn_flags = flags_reg;

endmodule

`default_nettype wire

### hdl/rprop_scale.sv
// Second and third pipeline stages: step times factor, then saturate and clamp.
`default_nettype none

module rprop_scale #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [DATA_WIDTH-1:0]             step_lo,
    input  wire logic [DATA_WIDTH-1:0]             step_hi,
    input  wire logic                              up_valid,
    output logic                                   up_stall,
    input  wire logic [DATA_WIDTH-1:0]             up_param,
    input  wire logic [DATA_WIDTH-1:0]             up_grad,
    input  wire logic [DATA_WIDTH-1:0]             up_step,
    input  wire logic [rprop_pkg::ETA_W-1:0]       up_eta,
    input  wire rprop_pkg::rprop_flags_t           up_flags,
    output logic                                   dn_valid,
    input  wire logic                              dn_stall,
    output logic      [DATA_WIDTH-1:0]             dn_param,
    output logic      [DATA_WIDTH-1:0]             dn_grad,
    output logic      [DATA_WIDTH-1:0]             dn_step,
    output rprop_pkg::rprop_flags_t                dn_flags
);
    import rprop_pkg::*;

    localparam int PROD_W = DATA_WIDTH + ETA_W;

    // Multiply stage registers
    logic                  mul_valid_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [DATA_WIDTH-1:0] mul_param_reg;
    logic [DATA_WIDTH-1:0] mul_grad_reg;
    logic [DATA_WIDTH-1:0] mul_step_reg;
    rprop_flags_t          mul_flags_reg;

    // Clamp stage registers
    logic                  clp_valid_reg;
    logic [DATA_WIDTH-1:0] clp_param_reg;
    logic [DATA_WIDTH-1:0] clp_grad_reg;
    logic [DATA_WIDTH-1:0] clp_step_reg;
    rprop_flags_t          clp_flags_reg;

    logic [PROD_W-1:0]     prod_next;
    logic [DATA_WIDTH-1:0] scaled;
    logic [DATA_WIDTH-1:0] raised;
    logic [DATA_WIDTH-1:0] step_next;
    logic                  mul_advance;
    logic                  clp_advance;

    assign clp_advance = !clp_valid_reg || !dn_stall;
    assign mul_advance = !mul_valid_reg || clp_advance;
    assign up_stall    = !mul_advance;

    // Full product of step and Q4.12 factor
    assign prod_next = PROD_W'(up_step) * PROD_W'(up_eta);

    // Drop the fraction bits, saturate, then clamp low first and high last
    always_comb
    begin
        if (|prod_reg[PROD_W-1:DATA_WIDTH+ETA_FRAC])
            scaled = '1;
        else
            scaled = prod_reg[DATA_WIDTH+ETA_FRAC-1:ETA_FRAC];
        step_next = mul_flags_reg.scale ? scaled : mul_step_reg;
        raised    = (step_next < step_lo) ? step_lo : step_next;
    end

    // Advance valid bits through both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            clp_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_advance)
                mul_valid_reg <= up_valid;
            if (clp_advance)
                clp_valid_reg <= mul_valid_reg;
        end
    end

    // Load multiply stage
    always_ff @(posedge clk)
    begin
        if (mul_advance && up_valid)
        begin
            prod_reg      <= prod_next;
            mul_param_reg <= up_param;
            mul_grad_reg  <= up_grad;
            mul_step_reg  <= up_step;
            mul_flags_reg <= up_flags;
        end
    end

    // Load clamp stage
    always_ff @(posedge clk)
    begin
        if (clp_advance && mul_valid_reg)
        begin
            clp_param_reg <= mul_param_reg;
            clp_grad_reg  <= mul_grad_reg;
            clp_step_reg  <= (raised > step_hi) ? step_hi : raised;
            clp_flags_reg <= mul_flags_reg;
        end
    end

    assign dn_valid = clp_valid_reg;
    assign dn_param = clp_param_reg;
    assign dn_grad  = clp_grad_reg;
    assign dn_step  = clp_step_reg;
    assign dn_flags = clp_flags_reg;

endmodule

`default_nettype wire

### hdl/rprop_apply.sv
// Final pipeline stage: saturating parameter move and result register.
`default_nettype none

module rprop_apply #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              up_valid,
    output logic                                   up_stall,
    input  wire logic [DATA_WIDTH-1:0]             up_param,
    input  wire logic [DATA_WIDTH-1:0]             up_grad,
    input  wire logic [DATA_WIDTH-1:0]             up_step,
    input  wire rprop_pkg::rprop_flags_t           up_flags,
    output logic                                   dn_valid,
    input  wire logic                              dn_stall,
    output logic      [DATA_WIDTH-1:0]             dn_param,
    output logic      [DATA_WIDTH-1:0]             dn_grad,
    output logic      [DATA_WIDTH-1:0]             dn_step,
    output logic                                   dn_last
);
    import rprop_pkg::*;

    localparam logic [DATA_WIDTH-1:0] SIGN_BIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] param_reg;
    logic [DATA_WIDTH-1:0] grad_reg;
    logic [DATA_WIDTH-1:0] step_reg;
    logic                  last_reg;

    logic [DATA_WIDTH-1:0] offs;
    logic [DATA_WIDTH:0]   sum;
    logic [DATA_WIDTH:0]   diff;
    logic [DATA_WIDTH-1:0] moved;
    logic                  advance;

    // Move in offset-binary form so saturation is a carry or borrow check
    always_comb
    begin
        offs = up_param ^ SIGN_BIT;
        sum  = {1'b0, offs} + {1'b0, up_step};
        diff = {1'b0, offs} - {1'b0, up_step};
        if (!up_flags.move)
            moved = offs;
        else if (up_flags.gneg)
            moved = sum[DATA_WIDTH] ? '1 : sum[DATA_WIDTH-1:0];
        else
            moved = diff[DATA_WIDTH] ? '0 : diff[DATA_WIDTH-1:0];
    end

    assign advance  = !valid_reg || !dn_stall;
    assign up_stall = !advance;

    // Hold result while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            param_reg <= moved ^ SIGN_BIT;
            grad_reg  <= up_grad;
            step_reg  <= up_step;
            last_reg  <= up_flags.last;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_param = param_reg;
    assign dn_grad  = grad_reg;
    assign dn_step  = step_reg;
    assign dn_last  = last_reg;

endmodule

`default_nettype wire

### hdl/rprop_update.sv
// Rprop element update: four-stage pipeline, one element per clock while the result side does not stall.
// An item passes the sign, multiply, clamp and apply registers in that order before its result is valid.
// Throughput: one item per cycle while no stage stalls; each stage holds under stall and bubbles collapse.
// The step multiply (data width by 16 bits) sets the stage depth.
// Reset clears all pipeline valid bits and loads the default configuration.
`default_nettype none

module rprop_update #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // item channel
    input  wire logic                                 item_valid,
    output logic                                      item_stall,
    input  wire logic signed [DATA_WIDTH-1:0]         param_in,
    input  wire logic signed [DATA_WIDTH-1:0]         grad_in,
    input  wire logic signed [DATA_WIDTH-1:0]         prev_grad_in,
    input  wire logic        [DATA_WIDTH-1:0]         step_in,
    input  wire logic                                 last_in,
    // result channel
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output logic signed      [DATA_WIDTH-1:0]         param_out,
    output logic signed      [DATA_WIDTH-1:0]         prev_grad_out,
    output logic             [DATA_WIDTH-1:0]         step_out,
    output logic                                      last_out,
    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic        [rprop_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [rprop_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rprop_pkg::*;

    logic [ETA_W-1:0]      eta_minus;
    logic [ETA_W-1:0]      eta_plus;
    logic [DATA_WIDTH-1:0] step_lo;
    logic [DATA_WIDTH-1:0] step_hi;
    logic                  maximize;

    logic                  s1_valid;
    logic                  s1_stall;
    logic [DATA_WIDTH-1:0] s1_param;
    logic [DATA_WIDTH-1:0] s1_grad;
    logic [DATA_WIDTH-1:0] s1_step;
    logic [ETA_W-1:0]      s1_eta;
    rprop_flags_t          s1_flags;

    logic                  s3_valid;
    logic                  s3_stall;
    logic [DATA_WIDTH-1:0] s3_param;
    logic [DATA_WIDTH-1:0] s3_grad;
    logic [DATA_WIDTH-1:0] s3_step;
    rprop_flags_t          s3_flags;

    logic [DATA_WIDTH-1:0] res_param;
    logic [DATA_WIDTH-1:0] res_grad;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    rprop_cfg #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eta_minus (eta_minus),
        .eta_plus  (eta_plus),
        .step_lo   (step_lo),
        .step_hi   (step_hi),
        .maximize  (maximize)
    );

    rprop_sign #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_sign (
        .clk       (clk),
        .rst_n     (rst_n),
        .eta_minus (eta_minus),
        .eta_plus  (eta_plus),
        .maximize  (maximize),
        .up_valid  (item_valid),
        .up_stall  (item_stall),
        .param     (param_in),
        .grad      (grad_in),
        .prev_grad (prev_grad_in),
        .step      (step_in),
        .last      (last_in),
        .dn_valid  (s1_valid),
        .dn_stall  (s1_stall),
        .dn_param  (s1_param),
        .dn_grad   (s1_grad),
        .dn_step   (s1_step),
        .dn_eta    (s1_eta),
        .dn_flags  (s1_flags)
    );

    rprop_scale #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_lo  (step_lo),
        .step_hi  (step_hi),
        .up_valid (s1_valid),
        .up_stall (s1_stall),
        .up_param (s1_param),
        .up_grad  (s1_grad),
        .up_step  (s1_step),
        .up_eta   (s1_eta),
        .up_flags (s1_flags),
        .dn_valid (s3_valid),
        .dn_stall (s3_stall),
        .dn_param (s3_param),
        .dn_grad  (s3_grad),
        .dn_step  (s3_step),
        .dn_flags (s3_flags)
    );

    rprop_apply #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_apply (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_stall (s3_stall),
        .up_param (s3_param),
        .up_grad  (s3_grad),
        .up_step  (s3_step),
        .up_flags (s3_flags),
        .dn_valid (result_valid),
        .dn_stall (result_stall),
        .dn_param (res_param),
        .dn_grad  (res_grad),
        .dn_step  (step_out),
        .dn_last  (last_out)
    );

    assign param_out     = res_param;
    assign prev_grad_out = res_grad;

endmodule

`default_nettype wire

### sim/rprop_checker.sv
// Channel monitor, element update predictor and result comparison for rprop_update.
module rprop_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    input  logic                               item_stall,
    input  logic [31:0]                        param_in,
    input  logic [31:0]                        grad_in,
    input  logic [31:0]                        prev_grad_in,
    input  logic [31:0]                        step_in,
    input  logic                               last_in,
    input  logic                               result_valid,
    input  logic                               result_stall,
    input  logic [31:0]                        param_out,
    input  logic [31:0]                        prev_grad_out,
    input  logic [31:0]                        step_out,
    input  logic                               last_out,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [rprop_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rprop_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 items_seen,
    output int                                 results_seen,
    output int                                 reversals,
    output int                                 param_clips
);
    timeunit 1ns;
    timeprecision 1ps;

    import rprop_pkg::*;

    localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
    localparam logic [31:0] MOST_POS  = 32'h7fff_ffff;
    localparam logic [63:0] UMAX      = 64'h0000_0000_ffff_ffff;
    localparam int          MAX_PRINT = 100;

    typedef struct packed {
        logic [31:0] param;
        logic [31:0] prev_grad;
        logic [31:0] step;
        logic        last;
    } upd_result_t;

    // Local copy of the configuration registers
    logic [ETA_W-1:0] shrink_q12;
    logic [ETA_W-1:0] grow_q12;
    logic [31:0]      step_floor;
    logic [31:0]      step_ceil;
    logic             ascend;

    upd_result_t expected_q[$];

    // Step times a Q4.12 factor, floored, saturated to the step range
    function automatic logic [63:0] scaled_step(input logic [31:0] s, input logic [15:0] eta);
        logic [63:0] prod;
        prod = ({32'd0, s} * {48'd0, eta}) >> ETA_FRAC;
        return (prod > UMAX) ? UMAX : prod;
    endfunction

    // Expected result of one element update under the current configuration
    function automatic upd_result_t rprop_predict(
        input  logic [31:0] p,
        input  logic [31:0] g,
        input  logic [31:0] pv,
        input  logic [31:0] s,
        input  logic        l,
        output bit          reversed,
        output bit          clipped
    );
        logic [31:0] gr;
        logic [63:0] ss;
        logic [63:0] u;
        bit          gneg;
        upd_result_t r;
        gr = g;
        if (ascend)
            gr = (g == SIGN_BIT) ? MOST_POS : (32'd0 - g);
        gneg = gr[31];
        reversed = 1'b0;
        clipped = 1'b0;
        ss = {32'd0, s};
        if (gr != 32'd0 && pv != 32'd0) begin
            if (gneg == pv[31])
                ss = scaled_step(s, grow_q12);
            else begin
                ss = scaled_step(s, shrink_q12);
                reversed = 1'b1;
            end
        end
        // max against the floor first, then min against the ceiling
        if (ss < {32'd0, step_floor})
            ss = {32'd0, step_floor};
        if (ss > {32'd0, step_ceil})
            ss = {32'd0, step_ceil};
        if (reversed)
            gr = 32'd0;
        // offset-binary parameter for a saturating move
        u = {32'd0, p ^ SIGN_BIT};
        if (gr != 32'd0) begin
            if (gneg) begin
                u = u + ss;
                if (u > UMAX) begin
                    u = UMAX;
                    clipped = 1'b1;
                end
            end
            else if (ss > u) begin
                u = 64'd0;
                clipped = 1'b1;
            end
            else
                u = u - ss;
        end
        r.param     = u[31:0] ^ SIGN_BIT;
        r.prev_grad = gr;
        r.step      = ss[31:0];
        r.last      = l;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < MAX_PRINT)
            $display("[%0t] result %0d: %s got %h expected %h",
                     $time, results_seen, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        upd_result_t want;
        bit          rev;
        bit          clip;
        if (!rst_n) begin
            shrink_q12 = ETA_MINUS_RST;
            grow_q12   = ETA_PLUS_RST;
            step_floor = STEP_MIN_RST;
            step_ceil  = STEP_MAX_RST;
            ascend     = 1'b0;
            expected_q.delete();
            pending      = 0;
            fail_count   = 0;
            items_seen   = 0;
            results_seen = 0;
            reversals    = 0;
            param_clips  = 0;
        end
        else begin
            // track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ETA_MINUS:     shrink_q12 = cfg_data[ETA_W-1:0];
                    REG_ETA_PLUS:      grow_q12   = cfg_data[ETA_W-1:0];
                    REG_STEP_MIN:      step_floor = cfg_data[31:0];
                    REG_STEP_MAX:      step_ceil  = cfg_data[31:0];
                    REG_MAXIMIZE_MODE: ascend     = cfg_data[0];
                    default: ;
                endcase
            end
            // predict each accepted element
            if (item_valid && !item_stall) begin
                want = rprop_predict(param_in, grad_in, prev_grad_in, step_in, last_in,
                                     rev, clip);
                expected_q.push_back(want);
                items_seen++;
                if (rev)
                    reversals++;
                if (clip)
                    param_clips++;
            end
            // compare each accepted result with the oldest prediction
            if (result_valid && !result_stall) begin
                if (expected_q.size() == 0)
                    report_mismatch("result with nothing outstanding", 64'd0, 64'd0);
                else begin
                    want = expected_q.pop_front();
                    if (param_out !== want.param)
                        report_mismatch("param_out", param_out, want.param);
                    if (prev_grad_out !== want.prev_grad)
                        report_mismatch("prev_grad_out", prev_grad_out, want.prev_grad);
                    if (step_out !== want.step)
                        report_mismatch("step_out", step_out, want.step);
                    if (last_out !== want.last)
                        report_mismatch("last_out", last_out, want.last);
                end
                results_seen++;
            end
            pending = expected_q.size();
        end
    end

endmodule

### sim/tb_rprop_update.sv
// Top of the rprop_update testbench: clock, reset, stimulus, watchdog and verdict.
module tb_rprop_update;
    timeunit 1ns;
    timeprecision 1ps;

    import rprop_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [31:0] param_in;
    logic [31:0] grad_in;
    logic [31:0] prev_grad_in;
    logic [31:0] step_in;
    logic        last_in;
    logic        result_valid;
    logic        result_stall;
    logic [31:0] param_out;
    logic [31:0] prev_grad_out;
    logic [31:0] step_out;
    logic        last_out;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int items_seen;
    int results_seen;
    int reversals;
    int param_clips;
    int n_settings;
    int idle_run;

    rprop_update #(.DATA_WIDTH(32)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .param_in      (param_in),
        .grad_in       (grad_in),
        .prev_grad_in  (prev_grad_in),
        .step_in       (step_in),
        .last_in       (last_in),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .param_out     (param_out),
        .prev_grad_out (prev_grad_out),
        .step_out      (step_out),
        .last_out      (last_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    rprop_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .param_in      (param_in),
        .grad_in       (grad_in),
        .prev_grad_in  (prev_grad_in),
        .step_in       (step_in),
        .last_in       (last_in),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .param_out     (param_out),
        .prev_grad_out (prev_grad_out),
        .step_out      (step_out),
        .last_out      (last_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .items_seen    (items_seen),
        .results_seen  (results_seen),
        .reversals     (reversals),
        .param_clips   (param_clips)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Signed field: zeros, extremes, small magnitudes and full-range values
    function automatic logic [31:0] pick_signed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 32'd0;
        if (r < 22) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                default: return 32'h0000_0001;
            endcase
        end
        if (r < 60)
            return $urandom_range(0, 1) ? $urandom_range(1, 32'h0004_0000)
                                        : 32'd0 - $urandom_range(1, 32'h0004_0000);
        return $urandom;
    endfunction

    // Step field: zero, all ones, near the usual clamp range, or anything
    function automatic logic [31:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 32'd0;
        if (r < 16)
            return 32'hffff_ffff;
        if (r < 60)
            return $urandom_range(0, 32'h0040_0000);
        return $urandom;
    endfunction

    // Present one element and hold it until the transfer, then idle for gap cycles
    task automatic send_item(input logic [31:0] p, input logic [31:0] g,
                             input logic [31:0] pv, input logic [31:0] s,
                             input logic l, input int gap);
        @(negedge clk);
        param_in     <= p;
        grad_in      <= g;
        prev_grad_in <= pv;
        step_in      <= s;
        last_in      <= l;
        item_valid   <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (gap > 0) begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_random(input int n);
        int gap;
        for (int k = 0; k < n; k++) begin
            // every fourth stretch of 32 elements runs back to back
            gap = ((k / 32) % 4 == 3) ? 0 : idle_gap();
            send_item(pick_signed(), pick_signed(), pick_signed(), pick_step(),
                      ($urandom_range(0, 3) == 0), gap);
        end
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        wait (pending == 0);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_setting(input logic [15:0] shrink, input logic [15:0] grow,
                                input logic [31:0] floor_v, input logic [31:0] ceil_v,
                                input logic asc);
        write_reg(REG_ETA_MINUS, {16'd0, shrink});
        write_reg(REG_ETA_PLUS, {16'd0, grow});
        write_reg(REG_STEP_MIN, floor_v);
        write_reg(REG_STEP_MAX, ceil_v);
        write_reg(REG_MAXIMIZE_MODE, {31'd0, asc});
        n_settings++;
    endtask

    // Drive the result side stall: runs of open cycles, then stalls
    initial begin
        int run;
        result_stall = 1'b0;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : idle_gap() + 1;
            @(negedge clk);
            result_stall <= 1'b0;
            repeat (run - 1) @(negedge clk);
            run = idle_gap();
            if (run > 0) begin
                @(negedge clk);
                result_stall <= 1'b1;
                repeat (run - 1) @(negedge clk);
            end
        end
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge clk) begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_run, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        param_in     = 32'd0;
        grad_in      = 32'd0;
        prev_grad_in = 32'd0;
        step_in      = 32'd0;
        last_in      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        n_settings   = 1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default settings: the special cases one by one
        send_item(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 0);
        send_item(32'h0001_0000, 32'h0000_8000, 32'h0000_0000, 32'h0002_0000, 1'b0, 1);
        send_item(32'h0000_0000, 32'h0000_0100, 32'h0000_0200, 32'h0001_0000, 1'b0, 0);
        send_item(32'h0000_0000, 32'hffff_ff00, 32'hffff_fe00, 32'h0001_0000, 1'b0, 2);
        send_item(32'h0005_0000, 32'h0000_0100, 32'hffff_ff00, 32'h0004_0000, 1'b0, 0);
        send_item(32'hfffb_0000, 32'hffff_ff00, 32'h0000_0100, 32'h0004_0000, 1'b1, 0);
        send_item(32'h7fff_ffff, 32'hffff_0000, 32'h8000_0000, 32'h0030_0000, 1'b0, 0);
        send_item(32'h8000_0000, 32'h0001_0000, 32'h7fff_ffff, 32'h0030_0000, 1'b0, 3);
        send_item(32'h1234_5678, 32'h0000_0001, 32'h0000_0001, 32'hffff_ffff, 1'b0, 0);
        send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 0);
        send_item(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 1'b1, 0);
        send_item(32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1234_5678, 1'b1, 0);
        send_item(32'hedcb_a987, 32'h0000_0000, 32'hffff_ffff, 32'hedcb_a987, 1'b0, 0);
        send_random(100);
        settle();

        // Ascend, zero shrink, largest growth, clamp wide open
        load_setting(16'h0000, 16'hffff, 32'h0000_0000, 32'hffff_ffff, 1'b1);
        send_item(32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0001_0000, 1'b0, 0);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 1'b1, 0);
        send_item(32'h8000_0001, 32'h0000_0001, 32'hffff_ffff, 32'h0000_1000, 1'b0, 0);
        send_item(32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 1'b0, 0);
        send_random(80);
        settle();

        // Crossed clamp bounds with reversed factors
        load_setting(16'hffff, 16'h0000, 32'h0020_0000, 32'h0010_0000, 1'b0);
        send_random(60);
        settle();

        // Two ordinary random settings
        for (int ph = 0; ph < 2; ph++) begin
            load_setting(16'($urandom_range(0, 4095)), 16'($urandom_range(4096, 8191)),
                         $urandom_range(0, 255), $urandom_range(32'h0001_0000, 32'h7fff_ffff),
                         1'($urandom_range(0, 1)));
            send_random(80);
            settle();
        end

        // Anything goes in every register
        load_setting(16'($urandom), 16'($urandom), $urandom, $urandom,
                     1'($urandom_range(0, 1)));
        send_random(60);
        settle();

        // Fully crossed extremes while ascending
        load_setting(16'h0000, 16'h0000, 32'hffff_ffff, 32'h0000_0000, 1'b1);
        send_random(40);
        settle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d elements and %0d results under %0d register settings",
                 items_seen, results_seen, n_settings);
        $display("Saw %0d sign reversals and %0d saturated parameter moves, %0d mismatches",
                 reversals, param_clips, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
